[rtl/core/msa_pkg.sv]
// msa_pkg: field widths, opcodes and status codes of the multi-stack block.
// No dependencies. Used by msa_if.sv and multi_stack_shared_array.sv.
`default_nettype none

package msa_pkg;

    localparam int OPCODE_W     = 2;
    localparam int STACK_NUM_W  = 4;
    localparam int VALUE_W      = 32;
    localparam int NUM_STACKS_W = 5;
    localparam int MAX_RESULTS  = 64;   // longest dump, bottom entries first

    localparam logic [OPCODE_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_POP  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DUMP = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NOP  = 2'd3;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_BADSTACK = 2'd3
    } t_status;

    typedef struct packed {
        t_status                    status;
        logic signed [VALUE_W-1:0]  value;
        logic                       last;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/msa_if.sv]
// msa_if: valid/ready channel interfaces of the multi-stack block
// (command, response, configuration). Depends on msa_pkg.
`default_nettype none

interface msa_cmd_if import msa_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic [STACK_NUM_W-1:0]     stack_number;
    logic signed [VALUE_W-1:0]  push_value;

    modport source (output valid, opcode, stack_number, push_value, input ready);
    modport sink   (input valid, opcode, stack_number, push_value, output ready);
endinterface

interface msa_rsp_if import msa_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic signed [VALUE_W-1:0]  read_value;
    logic                       last;

    modport source (output valid, status, read_value, last, input ready);
    modport sink   (input valid, status, read_value, last, output ready);
endinterface

interface msa_cfg_if import msa_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [NUM_STACKS_W-1:0]    num_stacks;

    modport source (output valid, num_stacks, input ready);
    modport sink   (input valid, num_stacks, output ready);
endinterface

`default_nettype wire

[rtl/core/multi_stack_shared_array.sv]
// multi_stack_shared_array: several stacks carved out of one shared word store.
// Depends on msa_pkg and the channel interfaces in msa_if.sv.
`default_nettype none

// One store of STORE_DEPTH words is split into equal regions, one per stack;
// the region size is STORE_DEPTH / num_stacks (count clamped to 1..MAX_STACKS).
// Each command transaction names an opcode and a stack. Push answers ok or
// overflow, pop answers the top word or underflow (status empty), dump streams
// the stack bottom to top (at most MAX_RESULTS words) with last on the final
// word, and an empty stack answers one empty result. A stack number at or
// above the active count answers bad-stack; opcode 3 is dropped silently.
// Timing: one command is handled at a time. From acceptance to the load of the
// output register: a bad stack number passes through S_EMIT only; push,
// overflow and empty pass through the fill read (S_FILL, S_EMIT), pop through
// the fill read and then the store read (S_FILL, S_POP, S_EMIT), and a dump
// goes through the fill read to its first word and then one word per cycle
// while the output register is free. Opcode 3 frees the command port on the
// next cycle. A result waiting in the output register does not block
// acceptance of the next command. A configuration write empties all stacks and
// computes the region size with a restoring divider, one quotient bit per
// cycle: the command port is held off until the divider has finished.
// Store contents are not cleared; only words below a stack's fill are read.
module multi_stack_shared_array import msa_pkg::*; #(
    parameter int STORE_DEPTH = 64,
    parameter int MAX_STACKS  = 16
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    msa_cmd_if.sink   i_cmd,
    msa_rsp_if.source o_rsp,
    msa_cfg_if.sink   i_cfg
);

    // fill / region width, address width, stack index width, count width
    localparam int FW     = $clog2(STORE_DEPTH + 1);
    localparam int AW     = $clog2(STORE_DEPTH);
    localparam int SW     = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int CNT_W  = $clog2(MAX_STACKS + 1);
    localparam int CW     = (CNT_W > STACK_NUM_W) ? CNT_W : STACK_NUM_W;
    localparam int BW     = $clog2(FW);
    localparam int PW     = FW + STACK_NUM_W;
    localparam int DUMP_MAX = (STORE_DEPTH < MAX_RESULTS) ? STORE_DEPTH : MAX_RESULTS;
    localparam logic [FW-1:0] DEPTH_V    = FW'(STORE_DEPTH);
    localparam logic [FW-1:0] DUMP_MAX_V = FW'(DUMP_MAX);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FILL = 5'b00010,   // fill word arriving from the fill table
        S_POP  = 5'b00100,   // popped word arriving from the store
        S_DUMP = 5'b01000,   // streaming store words out
        S_EMIT = 5'b10000    // single prepared result waiting for output slot
    } t_state;

    // ---------------------------------------------------------------
    // Memories: word store and per-stack fill table (synchronous reads)
    // ---------------------------------------------------------------
    logic [VALUE_W-1:0] store_mem [STORE_DEPTH];
    logic [FW-1:0]      fill_mem  [MAX_STACKS];

    logic               store_we, store_re;
    logic [AW-1:0]      store_wa, store_ra;
    logic [VALUE_W-1:0] store_wd;
    logic [VALUE_W-1:0] r_store_q;

    logic               fill_we, fill_re;
    logic [SW-1:0]      fill_wa, fill_ra;
    logic [FW-1:0]      fill_wd;
    logic [FW-1:0]      r_fill_q;

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            store_mem[store_wa] <= store_wd;
        end
        if (store_re) begin
            r_store_q <= store_mem[store_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            fill_mem[fill_wa] <= fill_wd;
        end
        if (fill_re) begin
            r_fill_q <= fill_mem[fill_ra];
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    t_state                    r_state, n_state;
    logic [MAX_STACKS-1:0]     r_fvalid, n_fvalid;   // fill entry written since clear
    logic                      r_fv_q, n_fv_q;       // valid bit of the fill read
    logic [CNT_W-1:0]          r_count, n_count;     // active stack count
    logic [FW-1:0]             r_region, n_region;   // words per stack

    // region divider
    logic                      r_div_busy, n_div_busy;
    logic [BW-1:0]             r_div_bit, n_div_bit;
    logic [CNT_W-1:0]          r_rem, n_rem;
    logic [FW-1:0]             r_quo, n_quo;

    // command being handled
    logic [OPCODE_W-1:0]       r_op, n_op;
    logic [SW-1:0]             r_k, n_k;
    logic [VALUE_W-1:0]        r_val, n_val;
    logic [AW-1:0]             r_base, n_base;
    logic [FW-1:0]             r_idx, n_idx;         // dump position
    logic [FW-1:0]             r_n, n_n;             // dump length
    t_result                   r_res, n_res;

    // output register
    logic                      r_out_valid, n_out_valid;
    t_result                   r_out, n_out;

    // ---------------------------------------------------------------
    // Combinational helpers
    // ---------------------------------------------------------------
    logic               cmd_fire, cfg_fire, out_free, bad_stack;
    logic [CNT_W-1:0]   cfg_count;
    logic [CNT_W:0]     div_trial;
    logic               div_qbit;
    logic [FW-1:0]      fill_cur;
    logic [AW-1:0]      top_addr;
    logic [PW-1:0]      base_prod;

    assign i_cmd.ready = (r_state == S_IDLE) && !r_div_busy;
    assign i_cfg.ready = 1'b1;
    assign cmd_fire    = i_cmd.valid && i_cmd.ready;
    assign cfg_fire    = i_cfg.valid;
    assign out_free    = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.read_value = r_out.value;
    assign o_rsp.last       = r_out.last;

    // clamp the written count into 1..MAX_STACKS
    always_comb begin
        priority if (i_cfg.num_stacks == '0) begin
            cfg_count = CNT_W'(1);
        end else if (int'(i_cfg.num_stacks) > MAX_STACKS) begin
            cfg_count = CNT_W'(MAX_STACKS);
        end else begin
            cfg_count = CNT_W'(i_cfg.num_stacks);
        end
    end

    assign bad_stack = CW'(i_cmd.stack_number) >= CW'(r_count);
    assign base_prod = PW'(i_cmd.stack_number) * PW'(r_region);

    assign div_trial = {r_rem, DEPTH_V[r_div_bit]};
    assign div_qbit  = div_trial >= {1'b0, r_count};

    assign fill_cur  = r_fv_q ? r_fill_q : '0;
    assign top_addr  = r_base + AW'(fill_cur);

    // ---------------------------------------------------------------
    // Next-state logic
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_fvalid    = r_fvalid;
        n_fv_q      = r_fv_q;
        n_count     = r_count;
        n_region    = r_region;
        n_div_busy  = r_div_busy;
        n_div_bit   = r_div_bit;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_op        = r_op;
        n_k         = r_k;
        n_val       = r_val;
        n_base      = r_base;
        n_idx       = r_idx;
        n_n         = r_n;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        store_we = 1'b0;
        store_wa = top_addr;
        store_wd = r_val;
        store_re = 1'b0;
        store_ra = top_addr;
        fill_we  = 1'b0;
        fill_wa  = r_k;
        fill_wd  = fill_cur;
        fill_re  = 1'b0;
        fill_ra  = SW'(i_cmd.stack_number);

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        // region divider: one quotient bit per cycle, MSB first
        if (r_div_busy) begin
            n_rem = div_qbit ? CNT_W'(div_trial - {1'b0, r_count}) : CNT_W'(div_trial);
            n_quo = {r_quo[FW-2:0], div_qbit};
            n_div_bit = r_div_bit - 1'b1;
            if (r_div_bit == '0) begin
                n_div_busy = 1'b0;
                n_region   = {r_quo[FW-2:0], div_qbit};
            end
        end

        if (cfg_fire) begin
            n_count    = cfg_count;
            n_fvalid   = '0;
            n_div_busy = 1'b1;
            n_div_bit  = BW'(FW - 1);
            n_rem      = '0;
            n_quo      = '0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (cmd_fire && i_cmd.opcode != OP_NOP) begin
                    n_op   = i_cmd.opcode;
                    n_k    = SW'(i_cmd.stack_number);
                    n_val  = i_cmd.push_value;
                    n_base = AW'(base_prod);
                    if (bad_stack) begin
                        n_res   = '{status: ST_BADSTACK, value: '0, last: 1'b1};
                        n_state = S_EMIT;
                    end else begin
                        fill_re = 1'b1;
                        n_fv_q  = r_fvalid[SW'(i_cmd.stack_number)];
                        n_state = S_FILL;
                    end
                end
            end

            S_FILL: begin
                n_state = S_EMIT;
                priority if (r_op == OP_PUSH) begin
                    if (fill_cur >= r_region) begin
                        n_res = '{status: ST_OVERFLOW, value: '0, last: 1'b1};
                    end else begin
                        store_we      = 1'b1;
                        fill_we       = 1'b1;
                        fill_wd       = fill_cur + 1'b1;
                        n_fvalid[r_k] = 1'b1;
                        n_res = '{status: ST_OK, value: '0, last: 1'b1};
                    end
                end else if (fill_cur == '0) begin
                    n_res = '{status: ST_EMPTY, value: '0, last: 1'b1};
                end else if (r_op == OP_POP) begin
                    fill_we       = 1'b1;
                    fill_wd       = fill_cur - 1'b1;
                    n_fvalid[r_k] = 1'b1;
                    store_re      = 1'b1;
                    store_ra      = top_addr - 1'b1;
                    n_state       = S_POP;
                end else begin
                    // dump: fetch bottom word, stream up to the clamped length
                    store_re = 1'b1;
                    store_ra = r_base;
                    n_idx    = '0;
                    n_n      = (fill_cur > DUMP_MAX_V) ? DUMP_MAX_V : fill_cur;
                    n_state  = S_DUMP;
                end
            end

            S_POP: begin
                n_res   = '{status: ST_OK, value: r_store_q, last: 1'b1};
                n_state = S_EMIT;
            end

            S_DUMP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{status: ST_OK, value: r_store_q,
                              last: (r_idx + 1'b1 == r_n)};
                    if (r_idx + 1'b1 == r_n) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx    = r_idx + 1'b1;
                        store_re = 1'b1;
                        store_ra = r_base + AW'(r_idx + 1'b1);
                    end
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // State registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fvalid    <= '0;
            r_count     <= CNT_W'(1);
            r_region    <= DEPTH_V;
            r_div_busy  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fvalid    <= n_fvalid;
            r_count     <= n_count;
            r_region    <= n_region;
            r_div_busy  <= n_div_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fv_q    <= n_fv_q;
        r_div_bit <= n_div_bit;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_op      <= n_op;
        r_k       <= n_k;
        r_val     <= n_val;
        r_base    <= n_base;
        r_idx     <= n_idx;
        r_n       <= n_n;
        r_res     <= n_res;
        r_out     <= n_out;
    end

endmodule

`default_nettype wire

[tb/msa_checker.sv]
// msa_checker: scoreboard for multi_stack_shared_array; mirrors the stacks and
// compares every response transaction. Depends on msa_pkg and msa_if.sv.
`timescale 1ns / 1ps

module msa_checker import msa_pkg::*; #(
    parameter int STORE_DEPTH = 64,
    parameter int MAX_STACKS  = 16
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    msa_cmd_if   i_cmd,
    msa_rsp_if   i_rsp,
    msa_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    logic [VALUE_W-1:0] stack_words [STORE_DEPTH];
    logic [6:0]         stack_depth [MAX_STACKS];
    logic [6:0]         words_per_stack;
    int unsigned        stacks_active;
    t_result            expected_rsp_q [$];

    // count write: clamp to 1..MAX_STACKS, resize regions, empty all stacks
    task automatic set_stack_count(input logic [NUM_STACKS_W-1:0] count);
        int unsigned n;
        n = count;
        if (n == 0) n = 1;
        if (n > MAX_STACKS) n = MAX_STACKS;
        stacks_active   = n;
        words_per_stack = 7'(STORE_DEPTH / n);
        for (int s = 0; s < MAX_STACKS; s++) stack_depth[s] = '0;
    endtask

    task automatic queue_result(input t_status st, input logic [VALUE_W-1:0] val,
                                input logic lst);
        t_result r;
        r.status = st;
        r.value  = val;
        r.last   = lst;
        expected_rsp_q.push_back(r);
    endtask

    task automatic predict_command(input logic [OPCODE_W-1:0] op,
                                   input logic [STACK_NUM_W-1:0] k,
                                   input logic [VALUE_W-1:0] val);
        int unsigned base;
        int unsigned fill;
        int unsigned n;
        if (op == OP_NOP) return;
        if (k >= stacks_active) begin
            queue_result(ST_BADSTACK, '0, 1'b1);
            return;
        end
        base = k * words_per_stack;
        fill = stack_depth[k];
        case (op)
            OP_PUSH: begin
                if (fill >= words_per_stack) begin
                    queue_result(ST_OVERFLOW, '0, 1'b1);
                end else begin
                    stack_words[base + fill] = val;
                    stack_depth[k] = 7'(fill + 1);
                    queue_result(ST_OK, '0, 1'b1);
                end
            end
            OP_POP: begin
                if (fill == 0) begin
                    queue_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    stack_depth[k] = 7'(fill - 1);
                    queue_result(ST_OK, stack_words[base + fill - 1], 1'b1);
                end
            end
            default: begin
                if (fill == 0) begin
                    queue_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    n = (fill > MAX_RESULTS) ? MAX_RESULTS : fill;
                    for (int unsigned i = 0; i < n; i++)
                        queue_result(ST_OK, stack_words[base + i], (i + 1 == n));
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            expected_rsp_q.delete();
            set_stack_count(NUM_STACKS_W'(1));
            o_fail_count = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) set_stack_count(i_cfg.num_stacks);
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_rsp_q.size() == 0) begin
                    $display("%0t: unexpected response: expected none, actual status=%0d value=%0d last=%0d",
                             $time, i_rsp.status, i_rsp.read_value, i_rsp.last);
                    o_fail_count++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (i_rsp.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, i_rsp.status);
                        o_fail_count++;
                    end
                    if (i_rsp.read_value !== want.value) begin
                        $display("%0t: read_value mismatch: expected %0d, actual %0d",
                                 $time, want.value, i_rsp.read_value);
                        o_fail_count++;
                    end
                    if (i_rsp.last !== want.last) begin
                        $display("%0t: last mismatch: expected %0d, actual %0d",
                                 $time, want.last, i_rsp.last);
                        o_fail_count++;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                predict_command(i_cmd.opcode, i_cmd.stack_number, i_cmd.push_value);
        end
        o_pending = expected_rsp_q.size();
    end

endmodule

[tb/tb_top.sv]
// tb_top: stimulus and verdict for multi_stack_shared_array; the checking is
// done by msa_checker. Depends on msa_pkg, msa_if.sv, msa_checker.sv.
`timescale 1ns / 1ps

module tb_top;
    import msa_pkg::*;

    localparam int STORE_DEPTH       = 64;
    localparam int MAX_STACKS        = 16;
    localparam int CYCLE_LIMIT       = 800000;
    localparam int SETTLE_CYCLES     = 12;   // settle gap before a count write and before the verdict
    localparam int LONG_STALL_CYCLES = 150;
    localparam int ITEMS_PER_PHASE   = 18;
    localparam int NUM_PHASES        = 6;

    // stack counts for the random phases; 31 exercises the upper clamp
    localparam logic [NUM_STACKS_W-1:0] PHASE_COUNTS [NUM_PHASES] =
        '{5'd2, 5'd16, 5'd7, 5'd31, 5'd1, 5'd4};

    logic        clk;
    logic        rst_n;
    int          fail_count;
    int          pending;
    int unsigned cycle_count;
    bit          quiet;            // no idling on either side (final phase)
    bit          long_stall_req;   // ask the response side for one long hold-off
    bit          long_stall_done;

    msa_cmd_if cmd_ch ();
    msa_rsp_if rsp_ch ();
    msa_cfg_if cfg_ch ();

    multi_stack_shared_array #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_STACKS  (MAX_STACKS)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    msa_checker #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_STACKS  (MAX_STACKS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd        (cmd_ch),
        .i_rsp        (rsp_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offer one command transaction, optionally after a random idle burst.
    // Valid stays high on return so back-to-back items need no extra edge.
    task automatic send_cmd(input logic [OPCODE_W-1:0] op, input int unsigned k,
                            input logic [VALUE_W-1:0] val);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.opcode       <= op;
        cmd_ch.stack_number <= k[STACK_NUM_W-1:0];
        cmd_ch.push_value   <= val;
        do @(posedge clk); while (!cmd_ch.ready);
    endtask

    // Count writes only happen with the block idle: nothing outstanding, and a
    // settle gap in case the last command was a dropped opcode.
    task automatic write_stack_count(input logic [NUM_STACKS_W-1:0] count);
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.num_stacks <= count;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Response side: random stall/accept bursts, one long hold-off on request,
    // always ready once the final phase starts.
    initial begin
        long_stall_done = 1'b0;
        forever begin
            if (long_stall_req && !long_stall_done) begin
                // sender keeps offering meanwhile, so the block backs up
                rsp_ch.ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge clk);
                long_stall_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        int unsigned      active;
        int unsigned      sent;
        int unsigned      pick;
        int unsigned      k;
        logic [OPCODE_W-1:0] op;

        quiet               = 1'b0;
        long_stall_req      = 1'b0;
        rst_n               <= 1'b0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.opcode       <= OP_NOP;
        cmd_ch.stack_number <= '0;
        cmd_ch.push_value   <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.num_stacks   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed: reset setting, one stack over the whole store ----
        send_cmd(OP_DUMP, 0, '0);              // dump of an empty stack
        send_cmd(OP_POP, 0, '0);               // underflow
        send_cmd(OP_PUSH, 15, 32'h0000_1234);  // stack number beyond active count
        send_cmd(OP_NOP, 0, 32'hFFFF_FFFF);    // unused opcode, no response
        send_cmd(OP_PUSH, 0, 32'h7FFF_FFFF);
        send_cmd(OP_PUSH, 0, 32'h8000_0000);
        send_cmd(OP_DUMP, 0, '0);              // two entries, bottom first
        send_cmd(OP_POP, 0, '0);
        send_cmd(OP_POP, 0, '0);

        // ---- directed: 16 stacks of 4 words, fill the top one past full ----
        write_stack_count(5'd16);
        for (int i = 0; i < 5; i++) send_cmd(OP_PUSH, 15, $urandom);  // 5th overflows
        send_cmd(OP_PUSH, 14, 32'hFFFF_FFFF);  // neighbor region must stay apart
        send_cmd(OP_DUMP, 15, '0);
        send_cmd(OP_POP, 15, '0);

        // ---- directed: count of zero acts as one stack ----
        write_stack_count(5'd0);
        send_cmd(OP_PUSH, 1, 32'h0000_0001);   // bad stack
        send_cmd(OP_PUSH, 0, '0);

        // ---- directed: count above the maximum clamps to 16 ----
        write_stack_count(5'd31);
        send_cmd(OP_PUSH, 15, '0);
        send_cmd(OP_DUMP, 15, '0);

        // ---- random phases: push-heavy so small regions reach overflow ----
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == NUM_PHASES - 1) quiet = 1'b1;
            write_stack_count(PHASE_COUNTS[ph]);
            active = PHASE_COUNTS[ph];
            if (active == 0) active = 1;
            if (active > MAX_STACKS) active = MAX_STACKS;
            if (ph == 1) long_stall_req = 1'b1;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                op = (pick < 50) ? OP_PUSH :
                     (pick < 70) ? OP_POP  :
                     (pick < 95) ? OP_DUMP : OP_NOP;
                // mostly valid stacks, some out-of-range numbers
                k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(0, active - 1);
                send_cmd(op, k, $urandom);
                if (op != OP_NOP) sent++;
            end
        end

        // ---- drain: everything answered, then a quiet tail for strays ----
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
